// ===== design/ascii_triaxis_frame_parser_unit_defines.svh =====
// Assertion macros for the three-axis frame parser.
// Included by the modules that check their own logic; depends on nothing.
`ifndef ASCII_TRIAXIS_FRAME_PARSER_UNIT_DEFINES_SVH
`define ASCII_TRIAXIS_FRAME_PARSER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset
`define ATFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Consequence that must hold in the cycle after the antecedent
`define ATFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ATFP_ASSERT(lbl, clk, rstn, prop, msg)
`define ATFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/atfp_pkg.sv =====
// Shared types, constants and the position decoder of the frame parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package atfp_pkg;

  localparam logic [4:0] LAST_POS       = 5'd17;
  localparam logic [4:0] POS_MAX        = 5'd31;
  localparam logic [7:0] SIGN_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] END_MARKER_RST = 8'h3B;
  localparam int         NUM_AXES       = 3;

  // What one byte position contributes
  typedef enum logic [1:0] {
    SLOT_SKIP,
    SLOT_SIGN,
    SLOT_WHOLE,
    SLOT_FRAC
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t  kind;
    logic [1:0]  axis;
  } pos_class_t;

  // Classified item handed from front to back
  typedef struct packed {
    slot_kind_t  kind;
    logic [1:0]  axis;
    logic [3:0]  digit;
    logic        last;
    logic        frame_ok;
  } token_t;

  // Control between front and queue
  typedef struct packed {
    logic   push;
    token_t tok;
  } push_req_t;

  // Map a byte position onto axis and slot kind
  function automatic pos_class_t classify_pos(input logic [4:0] pos);
    pos_class_t c;
    c.kind = SLOT_SKIP;
    c.axis = 2'd0;
    case (pos) inside
      5'd2:           begin c.kind = SLOT_SIGN;  c.axis = 2'd0; end
      [5'd3 : 5'd4]:  begin c.kind = SLOT_WHOLE; c.axis = 2'd0; end
      [5'd5 : 5'd6]:  begin c.kind = SLOT_FRAC;  c.axis = 2'd0; end
      5'd7:           begin c.kind = SLOT_SIGN;  c.axis = 2'd1; end
      [5'd8 : 5'd9]:  begin c.kind = SLOT_WHOLE; c.axis = 2'd1; end
      [5'd10 : 5'd11]: begin c.kind = SLOT_FRAC;  c.axis = 2'd1; end
      5'd12:          begin c.kind = SLOT_SIGN;  c.axis = 2'd2; end
      [5'd13 : 5'd14]: begin c.kind = SLOT_WHOLE; c.axis = 2'd2; end
      [5'd15 : 5'd16]: begin c.kind = SLOT_FRAC;  c.axis = 2'd2; end
      default:        begin c.kind = SLOT_SKIP;  c.axis = 2'd0; end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/ascii_triaxis_frame_parser_unit.sv =====
// Three-axis ASCII frame parser: one byte per cycle in when not stalled, one result
// per frame out. A frame's final byte goes through the queue entry, then the output
// register, which drives the result.
// Throughput: one byte every cycle unless the queue is full, set by the back end's
// per-byte accumulate; the two-entry queue and the output register keep input flowing
// while a result waits. Reset (rst_n low, synchronous): clears position, queue,
// accumulators and output valid, and sets the end marker to ';'.
`timescale 1ns / 1ps
`default_nettype none

module ascii_triaxis_frame_parser_unit
  import atfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,  // end_marker
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] frame_byte
  input  wire logic        in_tlast,     // frame_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,    // [14:0] x, [29:15] y, [44:30] z, rest zero
  output logic [0:0]       out_tuser     // [0] format_error
);

  push_req_t push_req;
  token_t    q_head;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  atfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_full      (q_full),
    .push_req    (push_req)
  );

  atfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  atfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== design/atfp_front.sv =====
// Front end: accepts bytes, tracks frame position and classifies each byte.
// Holds the end-marker register; depends on atfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atfp_front
  import atfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        q_full,
  output push_req_t        push_req
);

  logic [7:0] end_marker_r;
  logic [4:0] pos_r, pos_nxt;
  logic       accept;
  logic       is_digit;
  pos_class_t pclass;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Classify the incoming byte
  always_comb begin
    pclass   = classify_pos(pos_r);
    is_digit = (in_tdata >= CHAR_ZERO) && (in_tdata <= CHAR_NINE);
    push_req.push         = accept;
    push_req.tok.axis     = pclass.axis;
    push_req.tok.digit    = 4'(in_tdata - CHAR_ZERO);
    push_req.tok.last     = in_tlast;
    push_req.tok.frame_ok = (pos_r == LAST_POS) && (in_tdata == end_marker_r);
    case (pclass.kind)
      SLOT_SIGN:  push_req.tok.kind = (in_tdata == SIGN_MINUS) ? SLOT_SIGN : SLOT_SKIP;
      SLOT_WHOLE: push_req.tok.kind = is_digit ? SLOT_WHOLE : SLOT_SKIP;
      SLOT_FRAC:  push_req.tok.kind = is_digit ? SLOT_FRAC : SLOT_SKIP;
      default:    push_req.tok.kind = SLOT_SKIP;
    endcase
  end

  // Advance the saturating position, restart after the last byte
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_tlast) begin
        pos_nxt = 5'd0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= 5'd0;
      end_marker_r <= END_MARKER_RST;
    end else begin
      pos_r <= pos_nxt;
      if (cfg_wr_en) begin
        end_marker_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/atfp_queue.sv =====
// Two-entry queue of classified items between front and back.
// Depends on atfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_triaxis_frame_parser_unit_defines.svh"

module atfp_queue
  import atfp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  push_req_t   push_req,
  output logic        q_full,
  output logic        q_valid,
  output token_t      q_head,
  input  wire logic   q_pop
);

  token_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_head  = mem_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    case ({push_req.push, q_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push_req.push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push_req.push) begin
      mem_r[wr_ptr_r] <= push_req.tok;
    end
  end

  `ATFP_ASSERT(a_no_overflow, clk, rst_n, !(push_req.push && count_r == 2'd2), "queue overflow")
  `ATFP_ASSERT(a_no_underflow, clk, rst_n, !(q_pop && count_r == 2'd0), "queue underflow")

endmodule

`default_nettype wire

// ===== design/atfp_back.sv =====
// Back end: accumulates axis digits and forms one result per frame.
// Holds the output register; depends on atfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_triaxis_frame_parser_unit_defines.svh"

module atfp_back
  import atfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  input  token_t            q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata,
  output logic [0:0]        out_tuser
);

  logic [NUM_AXES-1:0] neg_r, neg_nxt;
  logic [6:0]          whole_r [NUM_AXES];
  logic [6:0]          whole_nxt [NUM_AXES];
  logic [1:0]          wcnt_r [NUM_AXES];
  logic [1:0]          wcnt_nxt [NUM_AXES];
  logic [6:0]          frac_r [NUM_AXES];
  logic [6:0]          frac_nxt [NUM_AXES];
  logic [1:0]          fcnt_r [NUM_AXES];
  logic [1:0]          fcnt_nxt [NUM_AXES];
  logic [14:0]         val [NUM_AXES];
  logic [13:0]         mag [NUM_AXES];
  logic [6:0]          frac_scaled [NUM_AXES];
  logic                digits_ok;
  logic                ok;
  logic                out_valid_r;
  logic [44:0]         out_data_r;
  logic                out_err_r;

  // Take non-final items at once, a final one only when the output slot frees
  assign q_pop = q_valid && (!q_head.last || !out_valid_r || out_tready);

  // Accumulate digits and signs, clear after the final item
  always_comb begin
    neg_nxt = neg_r;
    for (int a = 0; a < NUM_AXES; a++) begin
      whole_nxt[a] = whole_r[a];
      wcnt_nxt[a]  = wcnt_r[a];
      frac_nxt[a]  = frac_r[a];
      fcnt_nxt[a]  = fcnt_r[a];
      if (q_pop) begin
        if (q_head.last) begin
          whole_nxt[a] = 7'd0;
          wcnt_nxt[a]  = 2'd0;
          frac_nxt[a]  = 7'd0;
          fcnt_nxt[a]  = 2'd0;
          neg_nxt[a]   = 1'b0;
        end else if (q_head.axis == 2'(a)) begin
          case (q_head.kind)
            SLOT_SIGN: neg_nxt[a] = 1'b1;
            SLOT_WHOLE: begin
              whole_nxt[a] = 7'(whole_r[a] * 7'd10 + 7'(q_head.digit));
              wcnt_nxt[a]  = wcnt_r[a] + 2'd1;
            end
            SLOT_FRAC: begin
              frac_nxt[a] = 7'(frac_r[a] * 7'd10 + 7'(q_head.digit));
              fcnt_nxt[a] = fcnt_r[a] + 2'd1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Form the signed hundredths of each axis
  always_comb begin
    digits_ok = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      case (fcnt_r[a])
        2'd0:    frac_scaled[a] = 7'd0;
        2'd1:    frac_scaled[a] = 7'(frac_r[a] * 7'd10);
        default: frac_scaled[a] = frac_r[a];
      endcase
      mag[a] = 14'(whole_r[a] * 14'd100) + 14'(frac_scaled[a]);
      val[a] = neg_r[a] ? (15'd0 - {1'b0, mag[a]}) : {1'b0, mag[a]};
      if (wcnt_r[a] == 2'd0 && fcnt_r[a] == 2'd0) begin
        digits_ok = 1'b0;
      end
    end
    ok = q_head.frame_ok && digits_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r       <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        whole_r[a] <= 7'd0;
        wcnt_r[a]  <= 2'd0;
        frac_r[a]  <= 7'd0;
        fcnt_r[a]  <= 2'd0;
      end
    end else begin
      neg_r <= neg_nxt;
      for (int a = 0; a < NUM_AXES; a++) begin
        whole_r[a] <= whole_nxt[a];
        wcnt_r[a]  <= wcnt_nxt[a];
        frac_r[a]  <= frac_nxt[a];
        fcnt_r[a]  <= fcnt_nxt[a];
      end
      if (q_pop && q_head.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      out_data_r <= ok ? {val[2], val[1], val[0]} : 45'd0;
      out_err_r  <= !ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r};
  assign out_tuser  = out_err_r;

  `ATFP_ASSERT(a_err_zero, clk, rst_n, !(out_valid_r && out_err_r && out_data_r != 45'd0), "error result not zero")
  `ATFP_ASSERT_NEXT(a_last_gives_result, clk, rst_n, q_pop && q_head.last, out_valid_r, "final item gave no result")

endmodule

`default_nettype wire

// ===== dv/tb_ascii_triaxis_frame_parser_unit.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for the three-axis ASCII frame parser: directed frames, then
// random frames under several end markers and stall patterns. Depends on atfp_pkg and
// ascii_triaxis_frame_parser_unit only.
module tb_ascii_triaxis_frame_parser_unit;
  import atfp_pkg::*;

  localparam int         CLK_HALF_NS        = 5;
  localparam int         RESET_CYCLES       = 11;
  localparam int         SETTLE_CYCLES      = 8;
  localparam int         CYCLE_LIMIT        = 200000;
  localparam int         SEGMENTS           = 6;
  localparam int         FRAMES_PER_SEGMENT = 3;
  localparam int         AXIS_BASE          = 2;
  localparam int         AXIS_STRIDE        = 5;
  localparam int         SLOTS_PER_AXIS     = 4;
  localparam logic [7:0] PLUS_CHAR          = 8'h2B;
  localparam logic [7:0] NUL_MARK           = "^";
  localparam logic [7:0] FF_MARK            = "~";

  typedef struct packed {
    logic signed [14:0] x_rate;
    logic signed [14:0] y_rate;
    logic signed [14:0] z_rate;
    logic               format_error;
  } triaxis_rates_t;

  // One note per frame: a typed-in result replaces the predicted one
  typedef struct packed {
    logic           typed;
    triaxis_rates_t rates;
  } frame_note_t;

  typedef struct {
    string text;
    bit    typed;
    int    x_rate;
    int    y_rate;
    int    z_rate;
    bit    format_error;
  } directed_frame_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;     // [7:0] frame_byte
  logic        in_tlast    = 1'b0;   // frame_end
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;            // [14:0] x, [29:15] y, [44:30] z, rest zero
  logic [0:0]  out_tuser;            // [0] format_error

  int          tx_idle_pct = 9;
  int          rx_idle_pct = 50;
  int          error_count = 0;
  int unsigned cycle_count = 0;

  triaxis_rates_t expected_rates_q [$];
  frame_note_t    frame_notes_q [$];

  // Predictor copy of the register and the frame accumulators
  logic [7:0] end_marker_cfg = END_MARKER_RST;
  logic [4:0] frame_pos;
  logic [2:0] minus_axes;
  logic [6:0] whole_acc [NUM_AXES];
  logic [1:0] whole_cnt [NUM_AXES];
  logic [6:0] frac_acc [NUM_AXES];
  logic [1:0] frac_cnt [NUM_AXES];

  ascii_triaxis_frame_parser_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // Free-running clock
  always #CLK_HALF_NS clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void clear_frame_state();
    frame_pos  = '0;
    minus_axes = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      whole_acc[a] = '0;
      whole_cnt[a] = '0;
      frac_acc[a]  = '0;
      frac_cnt[a]  = '0;
    end
  endfunction

  // Signed hundredths of one axis; a lone fraction digit counts as tenths
  function automatic logic signed [14:0] axis_hundredths(input int a);
    logic [31:0] frac;
    logic [31:0] mag;
    case (frac_cnt[a])
      2'd0:    frac = 0;
      2'd1:    frac = frac_acc[a] * 10;
      default: frac = frac_acc[a];
    endcase
    mag = whole_acc[a] * 100 + frac;
    if (minus_axes[a]) mag = -mag;
    return mag[14:0];
  endfunction

  // Accumulate one frame byte; on the flagged last byte return 1 with the rates
  function automatic bit absorb_frame_byte(input logic [7:0] b, input logic last,
                                           output triaxis_rates_t rates);
    logic [4:0] pos;
    int         offs;
    int         axis;
    slot_kind_t kind;
    logic       is_digit;
    logic [3:0] digit;
    bit         frame_ok;
    pos      = frame_pos;
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    digit    = 4'(b - CHAR_ZERO);
    kind     = SLOT_SKIP;
    axis     = 0;
    if (pos >= 5'(AXIS_BASE) && pos < LAST_POS) begin
      offs = int'(pos) - AXIS_BASE;
      axis = offs / AXIS_STRIDE;
      case (offs % AXIS_STRIDE)
        0:       kind = SLOT_SIGN;
        1, 2:    kind = SLOT_WHOLE;
        default: kind = SLOT_FRAC;
      endcase
    end
    case (kind)
      SLOT_SIGN: begin
        if (b == SIGN_MINUS) minus_axes[axis] = 1'b1;
      end
      SLOT_WHOLE: begin
        if (is_digit) begin
          whole_acc[axis] = 7'(whole_acc[axis] * 10 + digit);
          whole_cnt[axis] = whole_cnt[axis] + 2'd1;
        end
      end
      SLOT_FRAC: begin
        if (is_digit) begin
          frac_acc[axis] = 7'(frac_acc[axis] * 10 + digit);
          frac_cnt[axis] = frac_cnt[axis] + 2'd1;
        end
      end
      default: ;
    endcase
    rates = '0;
    if (!last) begin
      // Saturate the position so that long frames stay rejected
      if (pos != POS_MAX) frame_pos = pos + 5'd1;
      return 1'b0;
    end
    frame_ok = (pos == LAST_POS) && (b == end_marker_cfg);
    for (int a = 0; a < NUM_AXES; a++)
      if (whole_cnt[a] == 2'd0 && frac_cnt[a] == 2'd0) frame_ok = 1'b0;
    if (frame_ok) begin
      rates.x_rate = axis_hundredths(0);
      rates.y_rate = axis_hundredths(1);
      rates.z_rate = axis_hundredths(2);
    end else begin
      rates.format_error = 1'b1;
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Predict on every accepted byte, compare every accepted result
  always @(posedge clk) begin : monitor
    triaxis_rates_t predicted;
    triaxis_rates_t want;
    frame_note_t    note;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (absorb_frame_byte(in_tdata, in_tlast, predicted)) begin
          want = predicted;
          if (frame_notes_q.size() != 0) begin
            note = frame_notes_q.pop_front();
            if (note.typed) want = note.rates;
          end
          expected_rates_q.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_rates_q.size() == 0) begin
          report_mismatch("result with no frame pending", int'($signed(out_tdata[14:0])), 0);
        end else begin
          want = expected_rates_q.pop_front();
          if ($signed(out_tdata[14:0]) != want.x_rate)
            report_mismatch("x_hundredths", int'($signed(out_tdata[14:0])), int'(want.x_rate));
          if ($signed(out_tdata[29:15]) != want.y_rate)
            report_mismatch("y_hundredths", int'($signed(out_tdata[29:15])), int'(want.y_rate));
          if ($signed(out_tdata[44:30]) != want.z_rate)
            report_mismatch("z_hundredths", int'($signed(out_tdata[44:30])), int'(want.z_rate));
          if (out_tuser[0] != want.format_error)
            report_mismatch("format_error", int'(out_tuser[0]), int'(want.format_error));
          if (out_tdata[47:45] != 3'd0)
            report_mismatch("tdata padding", int'(out_tdata[47:45]), 0);
        end
      end
    end
  end

  // Offer one item, with a random hold-off first, and wait for its handshake
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the input until every pending result has arrived
  task automatic wait_for_drain(input int extra_cycles);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_rates_q.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // Send one frame, flag its last byte, optionally drain before byte pause_at
  task automatic send_frame(input logic [7:0] bytes_q[$], input frame_note_t note,
                            input int pause_at);
    for (int i = 0; i < bytes_q.size(); i++) begin
      if (i == pause_at) wait_for_drain(0);
      if (i == bytes_q.size() - 1) frame_notes_q.push_back(note);
      send_item(bytes_q[i], i == bytes_q.size() - 1);
    end
  endtask

  initial begin
    directed_frame_t dir_rows [14];
    logic [7:0]      segment_markers [SEGMENTS];
    logic [7:0]      frame_bytes [$];
    frame_note_t     note;
    int              roll;
    int              pick;
    int              len;
    int              pause_frame;

    clear_frame_state();
    // '^' in a row stands for byte 8'h00 and '~' for byte 8'hFF
    dir_rows = '{
      '{"AB+1234-5678+0912;", 1'b0, 0, 0, 0, 1'b0},
      '{"AB-9999-9999-9999;", 1'b1, -9999, -9999, -9999, 1'b0},
      '{"AB+9999+9999+9999;", 1'b1, 9999, 9999, 9999, 1'b0},
      '{"AB-0000+0000-0000;", 1'b1, 0, 0, 0, 1'b0},
      '{"AB+1 2 +x3y4-  5 ;", 1'b0, 0, 0, 0, 1'b0},
      '{"AB+12  +    +1234;", 1'b1, 0, 0, 0, 1'b1},
      '{"AB+1234+5678+9012:", 1'b1, 0, 0, 0, 1'b1},
      '{"AB+1234+5678+901;", 1'b1, 0, 0, 0, 1'b1},
      '{"AB+1234+5678+90123;", 1'b1, 0, 0, 0, 1'b1},
      '{";", 1'b1, 0, 0, 0, 1'b1},
      '{"AB+1234+5678+9012+1234+5678+9012+1234+5678;", 1'b1, 0, 0, 0, 1'b1},
      '{"AB-  99+99  -9 9 ;", 1'b0, 0, 0, 0, 1'b0},
      '{"--+1234+5678+9012;", 1'b0, 0, 0, 0, 1'b0},
      '{"^~~/0:9^9^~0-:/5~;", 1'b0, 0, 0, 0, 1'b0}
    };
    segment_markers = '{8'h00, 8'hFF, 8'($urandom_range(255)), CHAR_ZERO, SIGN_MINUS,
                        END_MARKER_RST};

    // Hold reset, then release it once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset end marker
    foreach (dir_rows[r]) begin
      frame_bytes = {};
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        if (dir_rows[r].text[i] == NUL_MARK)     frame_bytes.push_back(8'h00);
        else if (dir_rows[r].text[i] == FF_MARK) frame_bytes.push_back(8'hFF);
        else                                     frame_bytes.push_back(dir_rows[r].text[i]);
      end
      note.typed              = dir_rows[r].typed;
      note.rates.x_rate       = 15'(dir_rows[r].x_rate);
      note.rates.y_rate       = 15'(dir_rows[r].y_rate);
      note.rates.z_rate       = 15'(dir_rows[r].z_rate);
      note.rates.format_error = dir_rows[r].format_error;
      send_frame(frame_bytes, note, (r == 4) ? 6 : -1);
    end

    // Random frames: each segment sets a new end marker, each pair a new stall pattern
    for (int s = 0; s < SEGMENTS; s++) begin
      case (s / 2)
        0:       begin tx_idle_pct = 9;  rx_idle_pct = 50; end
        1:       begin tx_idle_pct = 50; rx_idle_pct = 9;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      wait_for_drain(SETTLE_CYCLES);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= segment_markers[s];
      @(posedge clk);
      cfg_wr_en      <= 1'b0;
      end_marker_cfg  = segment_markers[s];

      pause_frame = $urandom_range(FRAMES_PER_SEGMENT - 1);
      for (int f = 0; f < FRAMES_PER_SEGMENT; f++) begin
        frame_bytes = {};
        roll = $urandom_range(99);
        if (roll < 85) begin
          // Build a well-formed body: two ignored bytes, then sign and slots per axis
          frame_bytes.push_back(8'($urandom_range(255)));
          frame_bytes.push_back(8'($urandom_range(255)));
          for (int a = 0; a < NUM_AXES; a++) begin
            pick = $urandom_range(99);
            if (pick < 45)      frame_bytes.push_back(SIGN_MINUS);
            else if (pick < 85) frame_bytes.push_back(PLUS_CHAR);
            else                frame_bytes.push_back(8'($urandom_range(255)));
            for (int k = 0; k < SLOTS_PER_AXIS; k++) begin
              if ($urandom_range(99) < 85)
                frame_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
              else
                frame_bytes.push_back(8'($urandom_range(255)));
            end
          end
          // Break the length of some frames: cut short or pad with random bytes
          if (roll >= 65) begin
            len = $urandom_range(1, 40);
            while (frame_bytes.size() > len - 1) void'(frame_bytes.pop_back());
            while (frame_bytes.size() < len - 1)
              frame_bytes.push_back(8'($urandom_range(255)));
          end
          if ($urandom_range(99) < 90) frame_bytes.push_back(end_marker_cfg);
          else                         frame_bytes.push_back(8'($urandom_range(255)));
        end else begin
          // Noise of any length
          len = $urandom_range(1, 40);
          repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
        end
        note = '0;
        send_frame(frame_bytes, note,
                   (f == pause_frame) ? int'($urandom_range(frame_bytes.size() - 1)) : -1);
      end
    end

    // Drain, let the pipeline settle, then give the verdict
    wait_for_drain(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
